// File: rtl/swbs_pkg.sv
// Package for the sorted word binary search block.
// Holds field widths, opcodes and the sequencer state type.
// No dependencies; swbs_if and the top level import it, swbs_ram does not.
`timescale 1ns / 1ps

package swbs_pkg;

   // Fixed widths of the channel and register fields.
   localparam int WORD_W  = 56;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   // Operation codes carried in the op field of a request beat.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Search sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

// File: rtl/swbs_if.sv
// Valid/ready channel interfaces for the sorted word binary search block.
// One interface for request beats and one for response beats.
// Depends on swbs_pkg for the field widths.
`timescale 1ns / 1ps

interface swbs_req_if;
   import swbs_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [INDEX_W-1:0] entry_index;
   logic [WORD_W-1:0]  word;

   modport source (output valid, output op, output entry_index, output word, input ready);
   modport sink   (input valid, input op, input entry_index, input word, output ready);
endinterface

interface swbs_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, output found, input ready);
   modport sink   (input valid, input found, output ready);
endinterface

// File: rtl/swbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the word table; has no dependencies.
`timescale 1ns / 1ps

module swbs_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sorted_word_binary_search.sv
// Sorted word table with binary-search lookup: top level.
// Depends on swbs_pkg, the channel interfaces in swbs_if and the swbs_ram table.
//
//   Channel   Direction  Beat contents                      Handshake
//   req_ch    in         op, entry_index, word              valid / ready
//   rsp_ch    out        found (one beat per lookup)        valid / ready
//   csr       in         entry_count                        csr_wr_en, no stall
//
// A load beat writes the table at its accept edge.
// A lookup moves from its accept through P probes and the done state to the response
// register, where P is at most ceil(log2(n+1)) for n searched entries (11 for 1024);
// each probe is one table read followed by one 56-bit compare.
// req_ch.ready is low from a lookup's accept until its result enters the response
// register; a result waits there for rsp_ch.ready while new beats are taken.
// Reset is synchronous and clears the sequencer, the response valid and entry_count;
// the table is not cleared and an entry reads as unknown until written.
`timescale 1ns / 1ps

module sorted_word_binary_search #(
   parameter int TABLE_DEPTH = 1024,
   parameter int WORD_CHARS  = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   swbs_req_if.sink                     req_ch,
   swbs_rsp_if.source                   rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [swbs_pkg::COUNT_W-1:0] csr_wr_data
);
   import swbs_pkg::*;

   // Stored word width: packed characters, limited by the word field.
   localparam int STORE_W = (8 * WORD_CHARS > WORD_W) ? WORD_W : 8 * WORD_CHARS;
   // Table address width and width of a bound that can hold the depth itself.
   localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int IDXW = (CW > INDEX_W) ? CW : INDEX_W;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  entry_count_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                found_ff, found_in;
   logic [STORE_W-1:0]  key_ff, key_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;

   logic                req_accept;
   logic                rsp_accept;
   logic [CMPW-1:0]     count_ext;
   logic [CW-1:0]       search_len;
   logic [CW:0]         mid_sum;
   logic [CW-1:0]       span;
   logic                probe_hit;
   logic                probe_less;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic                ram_re;
   logic [STORE_W-1:0]  ram_rdata;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_accept   = rsp_valid_ff && rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.found = rsp_found_ff;

   // Searched length is entry_count limited to the table depth.
   assign count_ext  = CMPW'(entry_count_ff);
   assign search_len = (count_ext > CMPW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                        : CW'(count_ext);

   // Middle of the open interval [lo, hi), rounded down.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CW{1'b0}}, 1'b1};
   assign span    = hi_ff - lo_ff;

   // The compare unit: probe word against the search key.
   assign probe_hit  = (key_ff == ram_rdata);
   assign probe_less = (key_ff < ram_rdata);

   // Loads beyond the table depth are dropped.
   assign ram_we    = req_accept && (req_ch.op == OP_LOAD)
                      && (IDXW'(req_ch.entry_index) < IDXW'(TABLE_DEPTH));
   assign ram_waddr = AW'(req_ch.entry_index);

   swbs_ram #(
      .WIDTH (STORE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ch.word[STORE_W-1:0]),
      .rd_en   (ram_re),
      .rd_addr (mid_in[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Next state and datapath control of the search sequencer.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_sum[CW:1];
      ram_re       = 1'b0;

      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_ch.op == OP_LOOKUP)) begin
               key_in   = req_ch.word[STORE_W-1:0];
               lo_in    = '0;
               hi_in    = search_len;
               found_in = 1'b0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // Issue the table read for the middle entry, or stop when empty.
            if (lo_ff < hi_ff) begin
               ram_re   = 1'b1;
               state_in = ST_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CMP: begin
            if (probe_hit) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               if (probe_less) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = CW'(mid_ff + 1'b1);
               end
               state_in = ST_PROBE;
            end
         end
         ST_DONE: begin
            // Move the result into the response register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
      end
   end

   // Search payload registers.
   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      found_ff     <= found_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
   end

   // The search interval never inverts while a lookup runs.
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PROBE) || (state_ff == ST_CMP)) |-> (lo_ff <= hi_ff))
      else $error("search bounds inverted");

   // The probed entry lies inside the current interval.
   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ((mid_ff >= lo_ff) && (mid_ff < hi_ff)))
      else $error("probe index outside search interval");

   // Every miss strictly shrinks the interval, so the search terminates.
   a_interval_shrinks: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CMP) && !probe_hit) |=> (span < $past(span)))
      else $error("search interval did not shrink");

   // The table is only written while no lookup is running.
   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("table written during a search");

   // A new response only comes out of the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the done state");

endmodule
